[hw/rtl/bfst_pkg.sv]
// Shared types and constants for the broadcast flood suppress table.
package bfst_pkg;

  localparam int unsigned KEY_W   = 48;
  localparam int unsigned SEC_W   = 32;
  localparam int unsigned USEC_W  = 20;
  localparam int unsigned TOS_W   = 16;
  localparam int unsigned CNT_W   = 11;  // holds counts up to 2047
  localparam int unsigned RCNT_W  = 7;

  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_PURGE = 1'b1;

  localparam logic REG_TO_SEC  = 1'b0;
  localparam logic REG_TO_USEC = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] source_address;
    logic [15:0] destination_port;
    logic [SEC_W-1:0]  now_seconds;
    logic [USEC_W-1:0] now_microseconds;
  } in_req_t;

  typedef struct packed {
    logic              verdict;
    logic              table_full;
    logic [RCNT_W-1:0] removed_count;
  } out_rsp_t;

  // Sweep token handed from cell to cell.
  typedef struct packed {
    logic             act;
    logic             hit;
    logic             drop;
    logic             free_seen;
    logic [CNT_W-1:0] count;
  } carry_t;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_e;

endpackage

[hw/rtl/bfst_cell.sv]
// One table entry: key, timestamp and valid bit, with local match and expiry test.
module bfst_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bfst_pkg::in_req_t      req_i,
  input  logic [bfst_pkg::TOS_W-1:0]  to_sec_i,
  input  logic [bfst_pkg::USEC_W-1:0] to_usec_i,
  input  logic                   commit_i,
  input  bfst_pkg::carry_t       carry_i,
  output bfst_pkg::carry_t       carry_o
);

  logic                          valid_q, valid_d;
  logic                          cand_q, cand_d;
  logic [bfst_pkg::KEY_W-1:0]    key_q;
  logic [bfst_pkg::SEC_W-1:0]    sec_q;
  logic [bfst_pkg::USEC_W-1:0]   usec_q;
  logic                          wr_time;
  logic                          match, expd;
  logic [bfst_pkg::SEC_W:0]      lim_s;
  logic [bfst_pkg::USEC_W:0]     lim_us;
  logic [bfst_pkg::KEY_W-1:0]    req_key;
  bfst_pkg::carry_t              carry_d, carry_q;

  assign req_key = {req_i.destination_port, req_i.source_address};
  assign lim_s   = {1'b0, sec_q} + {{(bfst_pkg::SEC_W+1-bfst_pkg::TOS_W){1'b0}}, to_sec_i};
  assign lim_us  = {1'b0, usec_q} + {1'b0, to_usec_i};
  assign match   = valid_q && (key_q == req_key);
  assign expd    = (lim_s < {1'b0, req_i.now_seconds}) ||
                   ((lim_s == {1'b0, req_i.now_seconds}) &&
                    (lim_us < {1'b0, req_i.now_microseconds}));

  always_comb begin
    carry_d = carry_i;
    valid_d = valid_q;
    cand_d  = cand_q;
    wr_time = 1'b0;
    if (carry_i.act) begin
      cand_d = 1'b0;
      if (req_i.func == bfst_pkg::FUNC_PURGE) begin
        if (valid_q && expd) begin
          valid_d       = 1'b0;
          carry_d.count = carry_i.count + 1'b1;
        end
      end else begin
        if (match && !carry_i.hit) begin
          carry_d.hit = 1'b1;
          if (expd) begin
            wr_time = 1'b1;
          end else begin
            carry_d.drop = 1'b1;
          end
        end
        if (!valid_q && !carry_i.free_seen) begin
          cand_d            = 1'b1;
          carry_d.free_seen = 1'b1;
        end
      end
    end
    if (commit_i && cand_q) begin
      valid_d = 1'b1;
      cand_d  = 1'b0;
      wr_time = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cand_q  <= 1'b0;
      carry_q <= '0;
    end else begin
      valid_q <= valid_d;
      cand_q  <= cand_d;
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_time) begin
      sec_q  <= req_i.now_seconds;
      usec_q <= req_i.now_microseconds;
    end
    if (commit_i && cand_q) begin
      key_q <= req_key;
    end
  end

  assign carry_o = carry_q;

endmodule

[hw/rtl/broadcast_flood_suppress_table_top.sv]
// Top level of the broadcast flood suppress table: request control and cell chain.
//
// Usage:
//   A request on in_req_i is either a check (key = destination port and
//   source address, plus the current time) or a purge of expired entries.
//   Each request yields exactly one result on out_rsp_o: send/drop verdict,
//   table-full flag for an unstorable new key, and the purge count.
//   The table is a chain of TABLE_ENTRIES cells. A sweep token enters cell 0
//   when a request is taken and moves one cell per cycle; each cell tests
//   its own entry against the held request as the token passes.
//   The result becomes valid once the token has walked the whole chain.
//   One request at a time: no new request is taken while a sweep runs.
//   A new key is written into the lowest free cell in the cycle the token
//   leaves the last cell, once no hit was found anywhere.
//   Reset empties the table at once (valid bits cleared) and loads the
//   timeout registers with 1 s and 0 us. No clearing pass is needed.
//   The result sits in an output register; while the receiver stalls it
//   holds, and no new request is taken until it is taken (or taken in the
//   same cycle).
//   Timeouts are written over the APB port at 0x0 (seconds) and 0x4 (us).
module broadcast_flood_suppress_table_top #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bfst_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bfst_pkg::out_rsp_t out_rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  bfst_pkg::state_e              state_q, state_d;
  bfst_pkg::in_req_t             req_q;
  logic [bfst_pkg::TOS_W-1:0]    to_sec_q;
  logic [bfst_pkg::USEC_W-1:0]   to_usec_q;
  bfst_pkg::out_rsp_t            rsp_q, rsp_d;
  logic                          out_valid_q;
  logic                          in_acc, done, commit;
  bfst_pkg::carry_t              chain [TABLE_ENTRIES+1];

  // --- configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      to_sec_q  <= bfst_pkg::TOS_W'(1);
      to_usec_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        bfst_pkg::REG_TO_SEC:  to_sec_q  <= pwdata[bfst_pkg::TOS_W-1:0];
        bfst_pkg::REG_TO_USEC: to_usec_q <= pwdata[bfst_pkg::USEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bfst_pkg::REG_TO_SEC:  prdata = {{(32-bfst_pkg::TOS_W){1'b0}}, to_sec_q};
      bfst_pkg::REG_TO_USEC: prdata = {{(32-bfst_pkg::USEC_W){1'b0}}, to_usec_q};
      default:               prdata = '0;
    endcase
  end

  // --- request control
  assign in_ready_o = (state_q == bfst_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign done       = chain[TABLE_ENTRIES].act;
  // store new key when a check sweep found no hit but a free cell
  assign commit     = done && (req_q.func == bfst_pkg::FUNC_CHECK) &&
                      !chain[TABLE_ENTRIES].hit && chain[TABLE_ENTRIES].free_seen;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bfst_pkg::ST_IDLE:  if (in_acc) state_d = bfst_pkg::ST_SWEEP;
      bfst_pkg::ST_SWEEP: if (done)   state_d = bfst_pkg::ST_IDLE;
      default:            state_d = bfst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rsp_d = '0;
    if (req_q.func == bfst_pkg::FUNC_PURGE) begin
      if (chain[TABLE_ENTRIES].count > bfst_pkg::CNT_W'(127)) begin
        rsp_d.removed_count = '1;
      end else begin
        rsp_d.removed_count = chain[TABLE_ENTRIES].count[bfst_pkg::RCNT_W-1:0];
      end
    end else begin
      rsp_d.verdict    = chain[TABLE_ENTRIES].drop;
      rsp_d.table_full = !chain[TABLE_ENTRIES].hit && !chain[TABLE_ENTRIES].free_seen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfst_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) req_q <= in_req_i;
    if (done)   rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // --- cell chain; token injected at the head on accept
  always_comb begin
    chain[0]     = '0;
    chain[0].act = in_acc;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    bfst_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .req_i     (in_acc ? in_req_i : req_q),
      .to_sec_i  (to_sec_q),
      .to_usec_i (to_usec_q),
      .commit_i  (commit),
      .carry_i   (chain[g]),
      .carry_o   (chain[g+1])
    );
  end

endmodule

[hw/rtl/bfst_checker.sv]
// Port-level checker for the broadcast flood suppress table, bound to the top.
module bfst_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input bfst_pkg::out_rsp_t out_rsp_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !out_valid_o)
    else $error("request accepted while sweep running");

  a_drop_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.verdict |-> !out_rsp_o.table_full
      && out_rsp_o.removed_count == '0)
    else $error("inconsistent result fields");

  a_no_ready_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken with result pending");

endmodule

bind broadcast_flood_suppress_table_top bfst_checker u_bfst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
